@@ hdl/wshp_pkg.sv @@
// ============================================================================
// WebSocket header parser package
// Shared constants, queue entry types and byte decode helpers.
// ============================================================================
`default_nettype none

package wshp_pkg;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_FORM_16 = 7'd126;
    localparam logic [6:0] LEN_FORM_64 = 7'd127;

    localparam logic [6:0] CTRL_LIMIT_RESET = 7'd125;

    localparam logic [3:0] EXT_NONE = 4'd0;
    localparam logic [3:0] EXT_16   = 4'd2;
    localparam logic [3:0] EXT_64   = 4'd8;
    localparam logic [3:0] KEY_LEN  = 4'd4;
    localparam logic [3:0] HDR_MIN  = 4'd2;
    localparam logic [3:0] HDR_REJ64 = 4'd10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       first_bad;
        logic       first_ctrl;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    function automatic logic opcode_known(input logic [3:0] op);
        logic known;
        known = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
                (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
        return known;
    endfunction

    function automatic logic [3:0] ext_bytes(input logic [6:0] short_len);
        logic [3:0] ext;
        ext = EXT_NONE;
        if (short_len == LEN_FORM_16) begin
            ext = EXT_16;
        end else if (short_len == LEN_FORM_64) begin
            ext = EXT_64;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

@@ hdl/wshp_front.sv @@
// ============================================================================
// WebSocket header parser front end
// Accepts header bytes, decodes the first-byte checks and queues them.
// ============================================================================
`default_nettype none

module wshp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_restart,
    output wshp_pkg::t_head    o_head,
    input  wire logic          i_pop
);
    import wshp_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  push;
    logic                  pop;
    t_entry                n_entry;

    assign o_stall = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    always_comb begin
        n_entry.data       = i_data_byte;
        n_entry.restart    = i_restart;
        n_entry.first_bad  = (i_data_byte[6:4] != 3'b000) || !opcode_known(i_data_byte[3:0]);
        n_entry.first_ctrl = i_data_byte[3];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ hdl/wshp_back.sv @@
// ============================================================================
// WebSocket header parser back end
// Walks the header byte positions, checks the frame and registers results.
// ============================================================================
`default_nettype none

module wshp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wshp_pkg::t_head    i_head,
    output logic               o_pop,
    input  wire logic [6:0]    i_max_ctrl,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_status,
    output logic [3:0]         o_opcode,
    output logic               o_final_flag,
    output logic               o_masked_flag,
    output logic [62:0]        o_payload_length,
    output logic [31:0]        o_masking_key,
    output logic [3:0]         o_header_bytes
);
    import wshp_pkg::*;

    logic [3:0]  r_pos,   n_pos;
    logic [7:0]  r_first, n_first;
    logic        r_first_bad, n_first_bad;
    logic        r_first_ctrl, n_first_ctrl;
    logic [6:0]  r_short, n_short;
    logic        r_mask,  n_mask;
    logic [63:0] r_len,   n_len;
    logic [31:0] r_key,   n_key;

    logic        emit;
    logic        reject;
    logic [3:0]  pos_eff;
    logic [3:0]  ext_cur;
    logic [3:0]  ext_new;
    logic [7:0]  b;
    logic        out_free;
    logic        load;

    logic        n_status;
    logic [62:0] n_plen;
    logic [31:0] n_mkey;
    logic [3:0]  n_hlen;

    always_comb begin
        b            = i_head.entry.data;
        n_pos        = r_pos;
        n_first      = r_first;
        n_first_bad  = r_first_bad;
        n_first_ctrl = r_first_ctrl;
        n_short      = r_short;
        n_mask       = r_mask;
        n_len        = r_len;
        n_key        = r_key;
        emit         = 1'b0;
        reject       = 1'b0;
        pos_eff      = i_head.entry.restart ? 4'd0 : r_pos;
        ext_cur      = ext_bytes(r_short);

        if (pos_eff == 4'd0) begin
            n_first      = b;
            n_first_bad  = i_head.entry.first_bad;
            n_first_ctrl = i_head.entry.first_ctrl;
            n_mask       = 1'b0;
            n_short      = '0;
            n_pos        = 4'd1;
        end else if (pos_eff == 4'd1) begin
            n_mask  = b[7];
            n_short = b[6:0];
            n_len   = '0;
            n_key   = '0;
            if (r_first_bad || (r_first_ctrl && ((b[6:0] > i_max_ctrl) || !r_first[7]))) begin
                emit   = 1'b1;
                reject = 1'b1;
            end else if ((ext_bytes(b[6:0]) == EXT_NONE) && !b[7]) begin
                emit = 1'b1;
            end else begin
                n_pos = 4'd2;
            end
        end else if (pos_eff < (HDR_MIN + ext_cur)) begin
            n_len = {r_len[55:0], b};
            n_pos = pos_eff + 4'd1;
            if (pos_eff == (4'd1 + ext_cur)) begin
                if ((ext_cur == EXT_64) && n_len[63]) begin
                    emit   = 1'b1;
                    reject = 1'b1;
                end else if (!r_mask) begin
                    emit = 1'b1;
                end
            end
        end else begin
            n_key = {r_key[23:0], b};
            n_pos = pos_eff + 4'd1;
            if (pos_eff >= (4'd5 + ext_cur)) begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            n_pos = 4'd0;
        end
    end

    always_comb begin
        ext_new  = ext_bytes(n_short);
        n_status = reject;
        if (reject) begin
            n_plen = '0;
            n_mkey = '0;
            n_hlen = (pos_eff == 4'd1) ? HDR_MIN : HDR_REJ64;
        end else begin
            case (ext_new)
                EXT_16:  n_plen = {47'd0, n_len[15:0]};
                EXT_64:  n_plen = n_len[62:0];
                default: n_plen = {56'd0, n_short};
            endcase
            n_mkey = n_mask ? n_key : 32'd0;
            n_hlen = HDR_MIN + ext_new + (n_mask ? KEY_LEN : 4'd0);
        end
    end

    assign out_free = !o_valid || !i_stall;
    assign o_pop    = i_head.valid && (!emit || out_free);
    assign load     = o_pop && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos <= n_pos;
            end
            if (load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first      <= n_first;
            r_first_bad  <= n_first_bad;
            r_first_ctrl <= n_first_ctrl;
            r_short      <= n_short;
            r_mask       <= n_mask;
            r_len        <= n_len;
            r_key        <= n_key;
        end
        if (load) begin
            o_status         <= n_status;
            o_opcode         <= n_first[3:0];
            o_final_flag     <= n_first[7];
            o_masked_flag    <= n_mask;
            o_payload_length <= n_plen;
            o_masking_key    <= n_mkey;
            o_header_bytes   <= n_hlen;
        end
    end

endmodule

`default_nettype wire

@@ hdl/websocket_header_parser_core.sv @@
// ============================================================================
// WebSocket frame header parser
// Parses a WebSocket frame header one byte per transaction.
// ============================================================================
// Usage: header bytes enter on the input channel (i_valid, o_stall) with
// i_restart marking a byte that must be taken as the first header byte.
// One transaction on the output channel (o_valid, i_stall) is produced per
// finished or rejected header; bytes that do not end a header give none.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the control
// frame length limit; it is always ready and should be written while idle.
// The last header byte of a result is written into the input queue and is
// then parsed from the queue head straight into the output register.
// Throughput: one byte per cycle while no result waits on a stalled
// receiver, set by the single parse step per byte.
// When the receiver stalls, a waiting result holds; bytes that end no header
// still flow, and the two-entry input queue raises o_stall once it fills.
// Reset clears the queue, the byte position and the output valid, and sets
// the control frame limit to 125.
// ============================================================================
`default_nettype none

module websocket_header_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic [3:0]       o_opcode,
    output logic             o_final_flag,
    output logic             o_masked_flag,
    output logic [62:0]      o_payload_length,
    output logic [31:0]      o_masking_key,
    output logic [3:0]       o_header_bytes,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);
    import wshp_pkg::*;

    logic [6:0] r_max_ctrl;
    t_head      head;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ctrl <= CTRL_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_ctrl <= i_cfg_data;
        end
    end

    wshp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_head      (head),
        .i_pop       (pop)
    );

    wshp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .i_max_ctrl       (r_max_ctrl),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_opcode         (o_opcode),
        .o_final_flag     (o_final_flag),
        .o_masked_flag    (o_masked_flag),
        .o_payload_length (o_payload_length),
        .o_masking_key    (o_masking_key),
        .o_header_bytes   (o_header_bytes)
    );

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_payload_length == '0) && (o_masking_key == '0))
        else $error("rejected header carries length or key");

    a_reject_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_header_bytes == HDR_MIN) || (o_header_bytes == HDR_REJ64))
        else $error("rejected header has unexpected byte count");

    a_unmasked_key : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_masked_flag |-> (o_masking_key == '0))
        else $error("unmasked header carries a key");

    a_pop_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("parse stage consumed from an empty queue");

endmodule

`default_nettype wire
